### rtl/core/correlation_cost_volume_unit_macros.svh
// Assertion macros for the correlation cost volume unit.
// Expects clk_i and rst_ni in the scope of use.
`ifndef CORRELATION_COST_VOLUME_UNIT_MACROS_SVH
`define CORRELATION_COST_VOLUME_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CCV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CCV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ccv_pkg.sv
// Shared types, constants and helpers of the correlation cost volume unit.
// No dependencies.
package ccv_pkg;

  localparam int MAX_CHANNELS    = 64;
  localparam int MAX_HEIGHT      = 64;
  localparam int MAX_WIDTH       = 64;
  localparam int KERNEL_DILATION = 1;

  localparam int MAP_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  localparam int VAL_W   = 16;   // Q8.8 feature value
  localparam int PROD_W  = 32;   // Q16.16 product
  localparam int ACC_W   = 48;   // Q32.16 sum
  localparam int REG_W   = 7;    // widest register
  localparam int COORD_W = 10;   // signed map coordinate
  localparam int PS_W    = 4;    // patch size
  localparam int QDIV_W  = 8;    // displacement counter, below patch_size^2 when valid
  localparam int DIV_CNT_W = $clog2(QDIV_W);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_CHANNELS = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_PSIZE    = 3'd3,
    REG_PDIL     = 3'd4,
    REG_KSIZE    = 3'd5,
    REG_PAD      = 3'd6,
    REG_STRIDE   = 3'd7
  } reg_idx_e;

  // effective configuration (clamped)
  typedef struct packed {
    logic [6:0] nc;
    logic [6:0] nh;
    logic [6:0] nw;
    logic [3:0] ps;
    logic [2:0] pd;
    logic [1:0] ks;
    logic [2:0] pad;
    logic [2:0] st;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } rd_req_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic flag;
  } seq_stat_t;

  function automatic logic [6:0] clamp_dim(input logic [6:0] v, input int hi);
    if (v == 7'd0) return 7'd1;
    if (int'(v) > hi) return 7'(hi);
    return v;
  endfunction

  function automatic logic in_span(input coord_t x, input logic [6:0] n);
    return !x[COORD_W-1] && (x[COORD_W-2:0] < (COORD_W-1)'(n));
  endfunction

  function automatic logic [ADDR_W-1:0] map_addr(input logic [6:0] c,
                                                 input logic [COORD_W-2:0] r,
                                                 input logic [COORD_W-2:0] q);
    logic [31:0] lin;
    lin = (32'(c) * 32'(MAX_HEIGHT) + 32'(r)) * 32'(MAX_WIDTH) + 32'(q);
    return lin[ADDR_W-1:0];
  endfunction

endpackage

### rtl/core/ccv_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module ccv_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ccv_div.sv
// Restoring divider, one quotient bit per cycle: displacement counter by patch size.
// Depends on ccv_pkg.
module ccv_div import ccv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [QDIV_W-1:0] dividend_i,
  input  logic [PS_W-1:0]   divisor_i,   // nonzero, held stable
  output logic              done_o,
  output logic [QDIV_W-1:0] quo_o,
  output logic [PS_W-1:0]   rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [QDIV_W-1:0]    quo_q, quo_d;
  logic [PS_W-1:0]      rem_q, rem_d;
  logic [PS_W:0]        trial;
  logic                 fits;

  assign trial = {rem_q, quo_q[QDIV_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[QDIV_W-2:0], fits};
      rem_d = fits ? PS_W'(trial - {1'b0, divisor_i}) : trial[PS_W-1:0];
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(QDIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

### rtl/core/ccv_mac.sv
// Multiply-accumulate behind the map RAM read ports: product register, 48-bit sum.
// Depends on ccv_pkg.
module ccv_mac import ccv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  logic                    issue_i,   // read issued this cycle
  input  logic signed [VAL_W-1:0] a_i,       // valid the cycle after issue
  input  logic signed [VAL_W-1:0] b_i,
  output logic                    idle_o,
  output logic signed [ACC_W-1:0] acc_o
);

  logic                     dat_vld_q;
  logic                     prod_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  always_comb begin
    acc_d = acc_q;
    if (clear_i) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dat_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      dat_vld_q  <= issue_i;
      prod_vld_q <= dat_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dat_vld_q) begin
      prod_q <= a_i * b_i;
    end
    acc_q <= acc_d;
  end

  assign idle_o = !dat_vld_q && !prod_vld_q;
  assign acc_o  = acc_q;

endmodule

### rtl/core/ccv_seq.sv
// Query sequencer: range check, displacement, walk over channels and kernel taps.
// Depends on ccv_pkg and ccv_div.
module ccv_seq import ccv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      start_i,
  input  logic [6:0] row_i,
  input  logic [6:0] col_i,
  input  logic [6:0] disp_i,
  input  logic      out_free_i,
  input  logic      mac_idle_i,
  output rd_req_t   rd_o,
  output seq_stat_t stat_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e     state_q, state_d;
  logic       flag_q, flag_d;
  coord_t     u_q, u_d, v_q, v_d, sr_q, sr_d, sc_q, sc_d;
  logic [6:0] c_q, c_d;
  logic [1:0] i_q, i_d, j_q, j_d;

  // query check
  logic [COORD_W-1:0] cnt_w, rs, cs;
  logic [7:0]         pssq;
  coord_t             span_h, span_w;
  logic               flag_w;

  assign cnt_w  = COORD_W'(disp_i) * COORD_W'(cfg_i.pd);
  assign pssq   = 8'(cfg_i.ps) * 8'(cfg_i.ps);
  assign rs     = COORD_W'(row_i) * COORD_W'(cfg_i.st);
  assign cs     = COORD_W'(col_i) * COORD_W'(cfg_i.st);
  assign span_h = $signed(COORD_W'(cfg_i.nh) + COORD_W'({cfg_i.pad, 1'b0})
                          - COORD_W'(cfg_i.ks));
  assign span_w = $signed(COORD_W'(cfg_i.nw) + COORD_W'({cfg_i.pad, 1'b0})
                          - COORD_W'(cfg_i.ks));
  // disp >= outc  <=>  disp*pd >= ps^2;  row >= oh  <=>  row*st > span
  assign flag_w = (cnt_w >= COORD_W'(pssq))
               || span_h[COORD_W-1] || (rs > COORD_W'(span_h))
               || span_w[COORD_W-1] || (cs > COORD_W'(span_w));

  // displacement divide
  logic              div_start, div_done;
  logic [QDIV_W-1:0] quo;
  logic [PS_W-1:0]   rem, rad;
  logic signed [4:0] dr, dc;

  assign div_start = (state_q == S_IDLE) && start_i && !flag_w;

  ccv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cnt_w[QDIV_W-1:0]),
    .divisor_i  (cfg_i.ps),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  assign rad = (cfg_i.ps - PS_W'(1)) >> 1;
  assign dr  = $signed({1'b0, quo[PS_W-1:0]}) - $signed({1'b0, rad});
  assign dc  = $signed({1'b0, rem}) - $signed({1'b0, rad});

  // current tap
  coord_t r1, r2, q1, q2;
  logic   tap_ok, last_tap, last_j, last_i;

  assign r1 = u_q + $signed(COORD_W'(i_q));
  assign r2 = r1 + sr_q;
  assign q1 = v_q + $signed(COORD_W'(j_q));
  assign q2 = q1 + sc_q;
  assign tap_ok = in_span(r1, cfg_i.nh) && in_span(r2, cfg_i.nh)
               && in_span(q1, cfg_i.nw) && in_span(q2, cfg_i.nw);
  assign last_j   = j_q == (cfg_i.ks - 2'd1);
  assign last_i   = i_q == (cfg_i.ks - 2'd1);
  assign last_tap = last_j && last_i && (c_q == (cfg_i.nc - 7'd1));

  assign rd_o.en     = (state_q == S_RUN) && tap_ok;
  assign rd_o.addr_a = map_addr(c_q, r1[COORD_W-2:0], q1[COORD_W-2:0]);
  assign rd_o.addr_b = map_addr(c_q, r2[COORD_W-2:0], q2[COORD_W-2:0]);

  always_comb begin
    state_d = state_q;
    flag_d  = flag_q;
    u_d     = u_q;
    v_d     = v_q;
    sr_d    = sr_q;
    sc_d    = sc_q;
    c_d     = c_q;
    i_d     = i_q;
    j_d     = j_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          flag_d  = flag_w;
          u_d     = $signed(rs - COORD_W'(cfg_i.pad));
          v_d     = $signed(cs - COORD_W'(cfg_i.pad));
          c_d     = '0;
          i_d     = '0;
          j_d     = '0;
          state_d = flag_w ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          sr_d    = COORD_W'(dr) * $signed(COORD_W'(cfg_i.pd));
          sc_d    = COORD_W'(dc) * $signed(COORD_W'(cfg_i.pd));
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (last_j) begin
          j_d = '0;
          if (last_i) begin
            i_d = '0;
            c_d = c_q + 7'd1;
          end else begin
            i_d = i_q + 2'd1;
          end
        end else begin
          j_d = j_q + 2'd1;
        end
        if (last_tap) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (mac_idle_i) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      flag_q  <= 1'b0;
      c_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      flag_q  <= flag_d;
      c_q     <= c_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q  <= u_d;
    v_q  <= v_d;
    sr_q <= sr_d;
    sc_q <= sc_d;
  end

  assign stat_o.idle = state_q == S_IDLE;
  assign stat_o.done = state_q == S_DONE;
  assign stat_o.flag = flag_q;

endmodule

### rtl/core/correlation_cost_volume_unit.sv
// Top level of the correlation cost volume unit: config registers, map RAMs, output word.
// Depends on ccv_pkg, ccv_ram, ccv_mac, ccv_seq and the assertion macro header.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  in       | in_valid_i/in_ready_o  | func_i value_i chan_i row_i col_i disp_index_i
//  out      | out_valid_o/out_ready_i| cost_o status_o
//  cfg      | cfg_we_i (no wait)     | cfg_idx_i cfg_wdata_i
//
// Load word: written straight into first or second map RAM.
// Query word, when in range: the bit-serial divide, then one tap per cycle through
//   the RAM read ports, then the read/multiply/add drain. A flagged query skips
//   the divide, the taps and the drain.
// in_ready_o is low from query accept until its result word moves to the output
//   register; loads never meet RAM reads, so the maps need no forwarding.
// The output register frees the sequencer while a result waits for out_ready_i.
// Reset clears control and loads the config defaults; map contents stay undefined until loaded.
`include "correlation_cost_volume_unit_macros.svh"

module correlation_cost_volume_unit import ccv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input words
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              func_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic [5:0]              chan_i,
  input  logic [6:0]              row_i,
  input  logic [6:0]              col_i,
  input  logic [6:0]              disp_index_i,
  // result words
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [ACC_W-1:0] cost_o,
  output logic                    status_o,
  // config writes
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_idx_i,
  input  logic [REG_W-1:0]        cfg_wdata_i
);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [6:0] channels_q, height_q, width_q;
  logic [3:0] psize_q;
  logic [2:0] pdil_q, pad_q, stride_q;
  logic [1:0] ksize_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_q <= 7'd64;
      height_q   <= 7'd64;
      width_q    <= 7'd64;
      psize_q    <= 4'd9;
      pdil_q     <= 3'd1;
      ksize_q    <= 2'd1;
      pad_q      <= 3'd0;
      stride_q   <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CHANNELS: channels_q <= cfg_wdata_i[6:0];
        REG_HEIGHT:   height_q   <= cfg_wdata_i[6:0];
        REG_WIDTH:    width_q    <= cfg_wdata_i[6:0];
        REG_PSIZE:    psize_q    <= cfg_wdata_i[3:0];
        REG_PDIL:     pdil_q     <= cfg_wdata_i[2:0];
        REG_KSIZE:    ksize_q    <= cfg_wdata_i[1:0];
        REG_PAD:      pad_q      <= cfg_wdata_i[2:0];
        REG_STRIDE:   stride_q   <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // Effective values: dims clamped to 1..MAX, zero steps/sizes read as one.
  cfg_t cfg;
  assign cfg.nc  = clamp_dim(channels_q, MAX_CHANNELS);
  assign cfg.nh  = clamp_dim(height_q, MAX_HEIGHT);
  assign cfg.nw  = clamp_dim(width_q, MAX_WIDTH);
  assign cfg.ps  = (psize_q == 4'd0) ? 4'd1 : psize_q;
  assign cfg.pd  = (pdil_q == 3'd0) ? 3'd1 : pdil_q;
  assign cfg.ks  = (ksize_q == 2'd0) ? 2'd1 : ksize_q;
  assign cfg.pad = pad_q;
  assign cfg.st  = (stride_q == 3'd0) ? 3'd1 : stride_q;

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  seq_stat_t   stat;
  rd_req_t     rd;
  logic        in_acc, is_query, load_ok, we_a, we_b;
  logic [ADDR_W-1:0] load_addr;

  assign in_ready_o = stat.idle;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_query   = in_acc && (func_e'(func_i) == FUNC_QUERY);
  // Out-of-range loads are dropped.
  assign load_ok    = ({1'b0, chan_i} < cfg.nc) && (row_i < cfg.nh) && (col_i < cfg.nw);
  assign we_a       = in_acc && load_ok && (func_e'(func_i) == FUNC_LOAD_A);
  assign we_b       = in_acc && load_ok && (func_e'(func_i) == FUNC_LOAD_B);
  assign load_addr  = map_addr({1'b0, chan_i}, (COORD_W-1)'(row_i), (COORD_W-1)'(col_i));

  // ---------------------------------------------------------------------------
  // Map memories
  // ---------------------------------------------------------------------------
  logic signed [VAL_W-1:0] a_data, b_data;

  ccv_ram #(.Depth(MAP_DEPTH), .Width(VAL_W)) u_first_map (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (load_addr),
    .wdata_i (value_i),
    .re_i    (rd.en),
    .raddr_i (rd.addr_a),
    .rdata_o (a_data)
  );

  ccv_ram #(.Depth(MAP_DEPTH), .Width(VAL_W)) u_second_map (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (load_addr),
    .wdata_i (value_i),
    .re_i    (rd.en),
    .raddr_i (rd.addr_b),
    .rdata_o (b_data)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and MAC
  // ---------------------------------------------------------------------------
  logic                    mac_idle, out_free;
  logic signed [ACC_W-1:0] acc;

  ccv_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .start_i    (is_query),
    .row_i      (row_i),
    .col_i      (col_i),
    .disp_i     (disp_index_i),
    .out_free_i (out_free),
    .mac_idle_i (mac_idle),
    .rd_o       (rd),
    .stat_o     (stat)
  );

  ccv_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (is_query),
    .issue_i (rd.en),
    .a_i     (a_data),
    .b_i     (b_data),
    .idle_o  (mac_idle),
    .acc_o   (acc)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                    out_valid_q, out_valid_d;
  logic signed [ACC_W-1:0] cost_q;
  logic                    status_q;
  logic                    out_load;

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = stat.done && out_free;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cost_q   <= stat.flag ? '0 : acc;   // flagged query returns zero
      status_q <= stat.flag;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cost_o      = cost_q;
  assign status_o    = status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CCV_ASSERT_NEXT(a_query_blocks_input, is_query, !in_ready_o, "query did not block input")
  `CCV_ASSERT_NOW(a_read_not_idle, rd.en, !in_ready_o, "map read while accepting words")
  `CCV_ASSERT_NOW(a_flag_zero_cost, out_valid_o && status_o, cost_o == '0, "flagged nonzero cost")

endmodule

### tb/sv/correlation_cost_volume_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of correlation_cost_volume_unit: map loads, cost queries, register settings.
// Depends on ccv_pkg and the correlation_cost_volume_unit RTL.

module correlation_cost_volume_unit_test;
  import ccv_pkg::*;

  localparam int SETTLE_CYCLES = 24;     // a load or flagged query is done well within this
  localparam int HOLD_CYCLES   = 600;    // long receiver hold-off, fills the block
  localparam int STALL_LIMIT   = 20000;  // cycles with no word moving on either channel

  // Predicts the cost word of each query and checks the words that come out.
  class cost_scoreboard;
    typedef struct {
      logic signed [ACC_W-1:0] cost;
      logic                    status;
    } cost_word_t;

    shortint    first_feat [MAP_DEPTH];
    shortint    second_feat[MAP_DEPTH];
    bit         first_set  [MAP_DEPTH];
    bit         second_set [MAP_DEPTH];
    cost_word_t expected_costs[$];

    logic [6:0] chan_reg, height_reg, width_reg;
    logic [3:0] psize_reg;
    logic [2:0] pdil_reg, pad_reg, stride_reg;
    logic [1:0] ksize_reg;

    // settings as the block uses them
    int nc_use, nh_use, nw_use, ps_use, pd_use, ks_use, pad_use, st_use;
    int disp_lim, grid_h, grid_w;

    int loads, queries, flagged, results, errors;

    function new();
      chan_reg   = 7'd64;
      height_reg = 7'd64;
      width_reg  = 7'd64;
      psize_reg  = 4'd9;
      pdil_reg   = 3'd1;
      ksize_reg  = 2'd1;
      pad_reg    = 3'd0;
      stride_reg = 3'd1;
      refresh();
    endfunction

    function int dim_clamp(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int one_if_zero(int v);
      return (v == 0) ? 1 : v;
    endfunction

    function int map_slot(int c, int r, int q);
      return (c * MAX_HEIGHT + r) * MAX_WIDTH + q;
    endfunction

    function void refresh();
      int dk, span_h, span_w;
      nc_use   = dim_clamp(int'(chan_reg), MAX_CHANNELS);
      nh_use   = dim_clamp(int'(height_reg), MAX_HEIGHT);
      nw_use   = dim_clamp(int'(width_reg), MAX_WIDTH);
      ps_use   = one_if_zero(int'(psize_reg));
      pd_use   = one_if_zero(int'(pdil_reg));
      ks_use   = one_if_zero(int'(ksize_reg));
      st_use   = one_if_zero(int'(stride_reg));
      pad_use  = int'(pad_reg);
      disp_lim = (ps_use * ps_use - 1) / pd_use + 1;
      dk       = (ks_use - 1) * KERNEL_DILATION + 1;
      span_h   = nh_use + 2 * pad_use - dk;
      span_w   = nw_use + 2 * pad_use - dk;
      grid_h   = (span_h < 0) ? 0 : span_h / st_use + 1;
      grid_w   = (span_w < 0) ? 0 : span_w / st_use + 1;
    endfunction

    function void set_reg(reg_idx_e idx, logic [6:0] v);
      case (idx)
        REG_CHANNELS: chan_reg   = v;
        REG_HEIGHT:   height_reg = v;
        REG_WIDTH:    width_reg  = v;
        REG_PSIZE:    psize_reg  = v[3:0];
        REG_PDIL:     pdil_reg   = v[2:0];
        REG_KSIZE:    ksize_reg  = v[1:0];
        REG_PAD:      pad_reg    = v[2:0];
        REG_STRIDE:   stride_reg = v[2:0];
        default: ;
      endcase
      refresh();
    endfunction

    function int pending();
      return expected_costs.size();
    endfunction

    // Called for every accepted input word, in acceptance order.
    function void note_word(func_e f, logic [15:0] v, logic [5:0] c, logic [6:0] r,
                            logic [6:0] q, logic [6:0] d);
      int cc, rr, qq, dd, cnt, rad, sr, sc, u, w, r1, r2, q1, q2;
      longint acc;
      cost_word_t e;
      cc = int'(c);
      rr = int'(r);
      qq = int'(q);
      dd = int'(d);
      case (f)
        FUNC_LOAD_A, FUNC_LOAD_B: begin
          loads++;
          if (cc < nc_use && rr < nh_use && qq < nw_use) begin
            if (f == FUNC_LOAD_A) begin
              first_feat[map_slot(cc, rr, qq)] = shortint'(v);
              first_set[map_slot(cc, rr, qq)]  = 1'b1;
            end else begin
              second_feat[map_slot(cc, rr, qq)] = shortint'(v);
              second_set[map_slot(cc, rr, qq)]  = 1'b1;
            end
          end
        end
        FUNC_QUERY: begin
          queries++;
          if (dd >= disp_lim || rr >= grid_h || qq >= grid_w) begin
            flagged++;
            e.cost   = '0;
            e.status = 1'b1;
          end else begin
            cnt = dd * pd_use;
            rad = (ps_use - 1) / 2;
            sr  = (cnt / ps_use - rad) * pd_use;
            sc  = (cnt % ps_use - rad) * pd_use;
            u   = rr * st_use - pad_use;
            w   = qq * st_use - pad_use;
            acc = 0;
            for (int ch = 0; ch < nc_use; ch++) begin
              for (int i = 0; i < ks_use; i++) begin
                r1 = u + i * KERNEL_DILATION;
                r2 = r1 + sr;
                if (r1 >= 0 && r1 < nh_use && r2 >= 0 && r2 < nh_use) begin
                  for (int j = 0; j < ks_use; j++) begin
                    q1 = w + j * KERNEL_DILATION;
                    q2 = q1 + sc;
                    if (q1 >= 0 && q1 < nw_use && q2 >= 0 && q2 < nw_use)
                      acc += longint'(first_feat[map_slot(ch, r1, q1)]) *
                             longint'(second_feat[map_slot(ch, r2, q2)]);
                  end
                end
              end
            end
            e.cost   = acc[ACC_W-1:0];
            e.status = 1'b0;
          end
          expected_costs.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic signed [ACC_W-1:0] cost, logic status);
      cost_word_t e;
      results++;
      if (expected_costs.size() == 0) begin
        $error("result word with no query outstanding: cost %0d status %0d", cost, status);
        errors++;
        return;
      end
      e = expected_costs.pop_front();
      if (cost !== e.cost) begin
        $error("cost: expected %0d, got %0d", e.cost, cost);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              func_i       = '0;
  logic signed [VAL_W-1:0] value_i      = '0;
  logic [5:0]              chan_i       = '0;
  logic [6:0]              row_i        = '0;
  logic [6:0]              col_i        = '0;
  logic [6:0]              disp_index_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic signed [ACC_W-1:0] cost_o;
  logic                    status_o;
  logic                    cfg_we_i     = 1'b0;
  logic [2:0]              cfg_idx_i    = '0;
  logic [REG_W-1:0]        cfg_wdata_i  = '0;

  cost_scoreboard sb;
  int   send_idle_pct  = 0;    // chance per cycle that the sender holds back
  int   recv_stall_pct = 0;    // chance per cycle that the receiver is not ready
  logic press_go       = 1'b0; // starts the long receiver hold-off
  logic press_done     = 1'b0;
  int   settings_done  = 0;
  int   quiet_cycles   = 0;

  always #5 clk_i = ~clk_i;

  correlation_cost_volume_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .value_i      (value_i),
    .chan_i       (chan_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .disp_index_i (disp_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cost_o       (cost_o),
    .status_o     (status_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Result side: check each accepted word, then pick ready for the next cycle.
  // DUT outputs are read at the edge, before its flops update, so they are
  // the values the handshake saw.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) sb.check_word(cost_o, status_o);
      if (press_go && !press_done) out_ready_i <= 1'b0;
      else out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // The hold-off is timed here, apart from the sender, which keeps offering words.
  initial begin
    wait (press_go);
    repeat (HOLD_CYCLES) @(posedge clk_i);
    press_done <= 1'b1;
  end

  // Watchdog: a hang shows up as a long run of cycles where no word moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("correlation_cost_volume_unit_test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Feature values lean on the Q8.8 extremes so the products reach full size.
  function automatic logic [15:0] feature_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one word and hold it until accepted. Entered and left right after a
  // rising edge; valid stays high into the next word unless the sender idles.
  task automatic send_word(input func_e f, input logic [15:0] v, input logic [5:0] c,
                           input logic [6:0] r, input logic [6:0] q, input logic [6:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    value_i      <= v;
    chan_i       <= c;
    row_i        <= r;
    col_i        <= q;
    disp_index_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(f, v, c, r, q, d);
  endtask

  // Write all eight registers back to back; only called with the block idle.
  task automatic apply_setting(input logic [6:0] vals [8]);
    for (int k = 0; k < 8; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= reg_idx_e'(k);
      cfg_wdata_i <= vals[k];
      @(posedge clk_i);
      sb.set_reg(reg_idx_e'(k), vals[k]);
    end
    cfg_we_i <= 1'b0;
    settings_done++;
  endtask

  // Stop offering, wait for every cost word, then let a trailing load or
  // flagged query finish inside the block.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Load every map entry in the region in use that was never written, so that
  // no query can read an undefined entry.
  task automatic fill_maps();
    int slot;
    for (int c = 0; c < sb.nc_use; c++)
      for (int r = 0; r < sb.nh_use; r++)
        for (int q = 0; q < sb.nw_use; q++) begin
          slot = sb.map_slot(c, r, q);
          if (!sb.first_set[slot])
            send_word(FUNC_LOAD_A, feature_value(), 6'(c), 7'(r), 7'(q), 7'($urandom));
          if (!sb.second_set[slot])
            send_word(FUNC_LOAD_B, feature_value(), 6'(c), 7'(r), 7'(q), 7'($urandom));
        end
  endtask

  // Mostly in-range loads and in-range queries; some noise and out-of-range words.
  task automatic random_words(input int n_words);
    int pick, lim_d;
    logic [6:0] r, q, d;
    for (int n = 0; n < n_words; n++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // anything at all, the unused function code included
        send_word(func_e'($urandom_range(3)), 16'($urandom), 6'($urandom), 7'($urandom),
                  7'($urandom), 7'($urandom));
      end else if (pick < 50) begin
        send_word((pick < 29) ? FUNC_LOAD_A : FUNC_LOAD_B, feature_value(),
                  6'($urandom_range(sb.nc_use - 1)), 7'($urandom_range(sb.nh_use - 1)),
                  7'($urandom_range(sb.nw_use - 1)), 7'($urandom));
      end else if (pick < 56) begin
        // load with a coordinate past the maps in use, dropped by the block
        send_word((pick < 53) ? FUNC_LOAD_A : FUNC_LOAD_B, feature_value(), 6'($urandom),
                  7'($urandom_range(127, sb.nh_use)), 7'($urandom), 7'($urandom));
      end else begin
        lim_d = (sb.disp_lim > 128) ? 128 : sb.disp_lim;
        d = 7'($urandom_range(lim_d - 1));
        r = (sb.grid_h > 0) ? 7'($urandom_range(sb.grid_h - 1)) : 7'($urandom);
        q = (sb.grid_w > 0) ? 7'($urandom_range(sb.grid_w - 1)) : 7'($urandom);
        // some queries get one field anywhere in its range, mostly flagged
        case ($urandom_range(9))
          0: d = 7'($urandom);
          1: r = 7'($urandom);
          2: q = 7'($urandom);
          default: ;
        endcase
        send_word(FUNC_QUERY, 16'($urandom), 6'($urandom), r, q, d);
      end
    end
  endtask

  task automatic run_setting(input logic [6:0] vals [8], input int n_words,
                             input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    apply_setting(vals);
    fill_maps();
    random_words(n_words);
    quiesce();
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: unused code, dropped loads, corner loads, flagged queries.
    send_word(FUNC_NONE, 16'hFFFF, 6'h3F, 7'h7F, 7'h7F, 7'h7F);
    send_word(FUNC_LOAD_A, 16'h1234, 6'd63, 7'd64, 7'd0, 7'd0);
    send_word(FUNC_LOAD_B, 16'h4321, 6'd0, 7'd0, 7'd64, 7'd0);
    send_word(FUNC_LOAD_A, 16'h8000, 6'd5, 7'd127, 7'd127, 7'd0);
    send_word(FUNC_LOAD_A, 16'h8000, 6'd63, 7'd63, 7'd63, 7'd0);
    send_word(FUNC_LOAD_B, 16'h7FFF, 6'd63, 7'd63, 7'd63, 7'd0);
    send_word(FUNC_LOAD_A, 16'h7FFF, 6'd0, 7'd0, 7'd0, 7'd0);
    send_word(FUNC_LOAD_B, 16'h8000, 6'd0, 7'd0, 7'd0, 7'd0);
    send_word(FUNC_QUERY, 16'h0000, 6'd0, 7'd0, 7'd0, 7'd81);
    send_word(FUNC_QUERY, 16'h0000, 6'd0, 7'd127, 7'd127, 7'd127);
    send_word(FUNC_QUERY, 16'h0000, 6'd0, 7'd64, 7'd0, 7'd0);
    send_word(FUNC_QUERY, 16'h0000, 6'd0, 7'd0, 7'd64, 7'd0);
    quiesce();

    // 3x3 maps, 3x3 kernel with one pad: every displacement at a corner, then the
    // opposite corner and the centre, then the first out-of-range index and row.
    apply_setting('{2, 3, 3, 3, 1, 3, 1, 1});
    fill_maps();
    for (int d = 0; d < 9; d++)
      send_word(FUNC_QUERY, 16'hFFFF, 6'h3F, 7'd0, 7'd0, 7'(d));
    send_word(FUNC_QUERY, 16'h0000, 6'd0, 7'd2, 7'd2, 7'd4);
    send_word(FUNC_QUERY, 16'h0000, 6'd0, 7'd1, 7'd1, 7'd0);
    send_word(FUNC_QUERY, 16'h0000, 6'd0, 7'd0, 7'd0, 7'd9);
    send_word(FUNC_QUERY, 16'h0000, 6'd0, 7'd3, 7'd0, 7'd0);
    random_words(120);
    quiesce();

    // channels, kernel and pad at their top; long queries
    run_setting('{64, 1, 1, 9, 1, 3, 4, 1}, 60, 80, 0);
    // tall maps, widest dilation and stride
    run_setting('{1, 64, 2, 9, 4, 2, 0, 4}, 150, 0, 80);
    // wide maps, single displacement
    run_setting('{1, 2, 64, 1, 1, 1, 2, 2}, 120, 14, 14);
    // zero writes fall back to one; pad beyond the nominal range
    run_setting('{0, 0, 0, 0, 0, 0, 7, 0}, 80, 80, 80);
    // channel count above the maximum, oversized patch
    run_setting('{100, 1, 1, 15, 3, 2, 3, 3}, 80, 0, 0);
    // kernel larger than the padded map: every query flagged
    run_setting('{3, 1, 2, 5, 2, 3, 0, 2}, 60, 80, 0);

    // Receiver holds off while the sender keeps going, so the input backs up.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    apply_setting('{2, 4, 4, 5, 1, 1, 0, 1});
    fill_maps();
    press_go <= 1'b1;
    random_words(150);
    quiesce();

    run_setting('{4, 5, 6, 7, 2, 3, 2, 1}, 180, 14, 14);

    if (sb.pending() != 0) begin
      $error("%0d cost words never arrived", sb.pending());
      sb.errors++;
    end
    $display("Ran %0d map loads and %0d cost queries (%0d out of range) over %0d register settings,",
             sb.loads, sb.queries, sb.flagged, settings_done);
    $display("with idle sender, stalled receiver and a %0d-cycle hold-off on the result side.",
             HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("correlation_cost_volume_unit_test passed");
    end else begin
      $display("correlation_cost_volume_unit_test failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ccv_pkg.sv
rtl/core/ccv_ram.sv
rtl/core/ccv_div.sv
rtl/core/ccv_mac.sv
rtl/core/ccv_seq.sv
rtl/core/correlation_cost_volume_unit.sv
tb/sv/correlation_cost_volume_unit_test.sv
